[rtl/osc_pkg.sv]
// Shared types, constants and helper functions for the overlay scaler setup calculator.
`timescale 1ns / 1ps
`default_nettype none

package osc_pkg;

  // Shared divider: 32-bit dividend, 13-bit divisor, two quotient bits per cycle.
  localparam int DIV_W      = 32;
  localparam int DEN_W      = 13;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Horizontal increment before and after normalization.
  localparam int H_W        = 23;
  localparam int H_NORM_W   = 13;
  localparam int STEP_W     = 4;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_FORMAT = 2'd1,
    ST_BAD_RECT   = 2'd2
  } osc_status_t;

  localparam logic [1:0] SRC_YUV422 = 2'd0;
  localparam logic [1:0] SRC_RGB565 = 2'd1;

  localparam logic [1:0] SCR_RGB555 = 2'd0;
  localparam logic [1:0] SCR_RGB565 = 2'd1;
  localparam logic [1:0] SCR_PAL8   = 2'd2;
  localparam logic [1:0] SCR_OTHER  = 2'd3;

  localparam logic [17:0] ACC_BASE        = 18'h28000;
  localparam logic [31:0] ACC_MID_MASK    = 32'h000f8000;
  localparam logic [31:0] ACC_HI_MASK_P1  = 32'hf0000000;
  localparam logic [31:0] ACC_HI_MASK_P23 = 32'h70000000;
  localparam logic [31:0] SCALE_CTL_YUV   = 32'h41ff0b03;
  localparam logic [31:0] SCALE_CTL_RGB   = 32'h41ff040f;
  localparam logic [23:0] KEY_MASK_555    = 24'h007fff;
  localparam logic [23:0] KEY_MASK_565    = 24'h00ffff;
  localparam logic [23:0] KEY_MASK_PAL8   = 24'h0000ff;
  localparam logic [23:0] KEY_MASK_FULL   = 24'hffffff;
  localparam logic [6:0]  KEY_CTL_ON      = 7'h50;
  localparam logic [6:0]  KEY_CTL_OFF     = 7'h01;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_h;
    logic div_v;
    logic h_capture;
    logic v_capture;
    logic norm;
    logic emit;
  } osc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic div_done;
    logic h_norm;
  } osc_stat_t;

  // Accumulator initial word: bits 15..11 of t land at 19..15, the high mask picks from t << 12.
  function automatic logic [31:0] accum_word(input logic [17:0] t, input logic [31:0] hi_mask);
    logic [31:0] t32;
    t32 = {14'd0, t};
    return ((t32 << 4) & ACC_MID_MASK) | ((t32 << 12) & hi_mask);
  endfunction

endpackage

`default_nettype wire

[rtl/osc_div.sv]
// Radix-4 restoring divider shared by the horizontal and vertical increments.
`timescale 1ns / 1ps
`default_nettype none

module osc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [osc_pkg::DIV_W-1:0]   dividend,
  input  logic [osc_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [osc_pkg::DIV_W-1:0]   quotient
);

  logic [osc_pkg::DIV_W-1:0]     quo;
  logic [osc_pkg::DEN_W-1:0]     rem;
  logic [osc_pkg::DEN_W-1:0]     den;
  logic [osc_pkg::DIV_CNT_W-1:0] cnt;
  logic                          running;

  logic [osc_pkg::DEN_W:0]       r1;
  logic [osc_pkg::DEN_W:0]       r2;
  logic [osc_pkg::DEN_W:0]       s1;
  logic [osc_pkg::DEN_W:0]       s2;
  logic                          ge1;
  logic                          ge2;
  logic [osc_pkg::DIV_W-1:0]     quo_next;
  logic [osc_pkg::DEN_W-1:0]     rem_next;

  // Two dependent compare-subtract steps per cycle; the remainder stays below the divisor.
  always_comb begin
    r1       = {rem, quo[osc_pkg::DIV_W-1]};
    ge1      = (r1 >= {1'b0, den});
    s1       = ge1 ? (r1 - {1'b0, den}) : r1;
    r2       = {s1[osc_pkg::DEN_W-1:0], quo[osc_pkg::DIV_W-2]};
    ge2      = (r2 >= {1'b0, den});
    s2       = ge2 ? (r2 - {1'b0, den}) : r2;
    rem_next = s2[osc_pkg::DEN_W-1:0];
    quo_next = {quo[osc_pkg::DIV_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == osc_pkg::DIV_CNT_W'(osc_pkg::DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (running) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

[rtl/osc_dp.sv]
// Datapath: request registers, divisions, normalization, key packing and result registers.
`timescale 1ns / 1ps
`default_nettype none

module osc_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic [11:0]         src_width,
  input  logic [11:0]         src_height,
  input  logic [11:0]         dst_left,
  input  logic [11:0]         dst_top,
  input  logic [11:0]         dst_right,
  input  logic [11:0]         dst_bottom,
  input  logic [23:0]         key_color,
  input  logic [1:0]          src_format,
  input  logic [1:0]          screen_format,
  input  osc_pkg::osc_cmd_t   cmd,
  output osc_pkg::osc_stat_t  stat,
  output logic [1:0]          status,
  output logic [28:0]         h_inc_word,
  output logic [15:0]         step_word,
  output logic [29:0]         v_inc_word,
  output logic [27:0]         start_word,
  output logic [27:0]         end_word,
  output logic [23:0]         key_value,
  output logic [23:0]         key_mask_word,
  output logic [6:0]          key_control,
  output logic [31:0]         accum_init_p1,
  output logic [31:0]         accum_init_p23,
  output logic [31:0]         scale_control
);

  logic                          colorkey_disable;

  logic [11:0]                   sw;
  logic [11:0]                   sh;
  logic [11:0]                   left;
  logic [11:0]                   top;
  logic [11:0]                   right;
  logic [11:0]                   bottom;
  logic [23:0]                   key;
  logic [1:0]                    sfmt;
  logic [1:0]                    scr;
  osc_pkg::osc_status_t          code;
  osc_pkg::osc_status_t          code_next;

  logic [osc_pkg::H_W-1:0]       h;
  logic [osc_pkg::STEP_W-1:0]    step;
  logic [29:0]                   vinc;

  logic [11:0]                   h_span;
  logic [11:0]                   v_span;
  logic                          div_start;
  logic [osc_pkg::DIV_W-1:0]     div_dividend;
  logic [osc_pkg::DEN_W-1:0]     div_divisor;
  logic                          div_done;
  logic [osc_pkg::DIV_W-1:0]     div_quotient;

  logic [osc_pkg::H_NORM_W-1:0]  hn;
  logic [17:0]                   t_p1;
  logic [17:0]                   t_p23;
  logic [31:0]                   p1;
  logic [23:0]                   kval;
  logic [23:0]                   kmask;

  always_ff @(posedge clk) begin
    if (rst) begin
      colorkey_disable <= 1'b0;
    end else if (cfg_wr_en) begin
      colorkey_disable <= cfg_wr_data;
    end
  end

  // Format check wins over the rectangle check.
  always_comb begin
    if (src_format != osc_pkg::SRC_YUV422 && src_format != osc_pkg::SRC_RGB565) begin
      code_next = osc_pkg::ST_BAD_FORMAT;
    end else if (dst_right < dst_left || dst_bottom < dst_top) begin
      code_next = osc_pkg::ST_BAD_RECT;
    end else begin
      code_next = osc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sw     <= src_width;
      sh     <= src_height;
      left   <= dst_left;
      top    <= dst_top;
      right  <= dst_right;
      bottom <= dst_bottom;
      key    <= key_color;
      sfmt   <= src_format;
      scr    <= screen_format;
      code   <= code_next;
    end
  end

  // Bit 0 of the source width and of the horizontal span is dropped (forced to zero).
  assign h_span    = right - left;
  assign v_span    = bottom - top;
  assign div_start = cmd.div_h | cmd.div_v;

  always_comb begin
    if (cmd.div_v) begin
      div_dividend = {sh, 20'd0};
      div_divisor  = {1'b0, v_span} + 13'd4;
    end else begin
      div_dividend = {8'd0, sw[11:1], 1'b0, 12'd0};
      div_divisor  = {1'b0, h_span[11:1], 1'b0} + 13'd4;
    end
  end

  osc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // While norm is set, halve h until it fits in H_NORM_W bits, one halving per cycle.
  always_ff @(posedge clk) begin
    if (cmd.h_capture) begin
      h    <= div_quotient[osc_pkg::H_W-1:0];
      step <= osc_pkg::STEP_W'(1);
    end else if (cmd.norm && !stat.h_norm) begin
      h    <= h >> 1;
      step <= step + 1'b1;
    end
    if (cmd.v_capture) begin
      vinc <= div_quotient[29:0];
    end
  end

  assign stat.err      = (code != osc_pkg::ST_OK);
  assign stat.div_done = div_done;
  assign stat.h_norm   = (h[osc_pkg::H_W-1:osc_pkg::H_NORM_W] == '0);

  assign hn    = h[osc_pkg::H_NORM_W-1:0];
  assign t_p1  = osc_pkg::ACC_BASE + {2'd0, hn, 3'd0};
  assign t_p23 = osc_pkg::ACC_BASE + {3'd0, hn, 2'd0};
  assign p1    = osc_pkg::accum_word(t_p1, osc_pkg::ACC_HI_MASK_P1);

  always_comb begin
    unique case (scr)
      osc_pkg::SCR_RGB555: begin
        kval  = {9'd0, key[23:19], key[15:11], key[7:3]};
        kmask = osc_pkg::KEY_MASK_555;
      end
      osc_pkg::SCR_RGB565: begin
        kval  = {8'd0, key[23:19], key[15:10], key[7:3]};
        kmask = osc_pkg::KEY_MASK_565;
      end
      osc_pkg::SCR_PAL8: begin
        kval  = key;
        kmask = osc_pkg::KEY_MASK_PAL8;
      end
      default: begin
        kval  = key;
        kmask = osc_pkg::KEY_MASK_FULL;
      end
    endcase
  end

  // A rejected request returns its status code with every other field zero.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= code;
      if (code != osc_pkg::ST_OK) begin
        h_inc_word     <= '0;
        step_word      <= '0;
        v_inc_word     <= '0;
        start_word     <= '0;
        end_word       <= '0;
        key_value      <= '0;
        key_mask_word  <= '0;
        key_control    <= '0;
        accum_init_p1  <= '0;
        accum_init_p23 <= '0;
        scale_control  <= '0;
      end else begin
        v_inc_word    <= vinc;
        start_word    <= {top, 4'd0, left};
        end_word      <= {bottom, 4'd0, right};
        key_value     <= kval;
        key_mask_word <= kmask;
        key_control   <= colorkey_disable ? osc_pkg::KEY_CTL_OFF : osc_pkg::KEY_CTL_ON;
        accum_init_p1 <= p1;
        if (sfmt == osc_pkg::SRC_YUV422) begin
          h_inc_word     <= {1'b0, hn[osc_pkg::H_NORM_W-1:1], 3'd0, hn};
          step_word      <= {4'd0, step, 4'd0, step};
          accum_init_p23 <= osc_pkg::accum_word(t_p23, osc_pkg::ACC_HI_MASK_P23);
          scale_control  <= osc_pkg::SCALE_CTL_YUV;
        end else begin
          h_inc_word     <= {hn, 3'd0, hn};
          step_word      <= 16'd1;
          accum_init_p23 <= p1;
          scale_control  <= osc_pkg::SCALE_CTL_RGB;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/osc_ctrl.sv]
// Controller: sequences the request check, both divisions, normalization and result output.
`timescale 1ns / 1ps
`default_nettype none

module osc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  osc_pkg::osc_stat_t  stat,
  output logic                busy,
  output logic                done,
  output osc_pkg::osc_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV_H = 6'b000100,
    S_DIV_V = 6'b001000,
    S_NORM  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start && !busy) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.err) begin
          state_next = S_EMIT;
        end else begin
          cmd.div_h  = 1'b1;
          state_next = S_DIV_H;
        end
      end
      S_DIV_H: begin
        if (stat.div_done) begin
          cmd.h_capture = 1'b1;
          cmd.div_v     = 1'b1;
          state_next    = S_DIV_V;
        end
      end
      // Normalization of the horizontal increment overlaps the vertical division.
      S_DIV_V: begin
        cmd.norm = 1'b1;
        if (stat.div_done) begin
          cmd.v_capture = 1'b1;
          state_next    = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (stat.h_norm) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.emit;
    end
  end

endmodule

`default_nettype wire

[rtl/overlay_scaler_setup_calc.sv]
// Top level of the overlay scaler setup calculator: controller plus datapath.
// An accepted request runs two radix-4 divisions one after the other in one divider.
// A rejected request (bad format or unordered rectangle) skips both divisions and normalization.
// A new item is taken in the cycle its predecessor's result shows.
// Reset is synchronous and clears the controller and colorkey_disable; busy is high during reset.
`timescale 1ns / 1ps
`default_nettype none

module overlay_scaler_setup_calc (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] src_width,
  input  logic [11:0] src_height,
  input  logic [11:0] dst_left,
  input  logic [11:0] dst_top,
  input  logic [11:0] dst_right,
  input  logic [11:0] dst_bottom,
  input  logic [23:0] key_color,
  input  logic [1:0]  src_format,
  input  logic [1:0]  screen_format,
  output logic        done,
  output logic [1:0]  status,
  output logic [28:0] h_inc_word,
  output logic [15:0] step_word,
  output logic [29:0] v_inc_word,
  output logic [27:0] start_word,
  output logic [27:0] end_word,
  output logic [23:0] key_value,
  output logic [23:0] key_mask_word,
  output logic [6:0]  key_control,
  output logic [31:0] accum_init_p1,
  output logic [31:0] accum_init_p23,
  output logic [31:0] scale_control
);

  osc_pkg::osc_cmd_t  cmd;
  osc_pkg::osc_stat_t stat;

  osc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  osc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .src_width      (src_width),
    .src_height     (src_height),
    .dst_left       (dst_left),
    .dst_top        (dst_top),
    .dst_right      (dst_right),
    .dst_bottom     (dst_bottom),
    .key_color      (key_color),
    .src_format     (src_format),
    .screen_format  (screen_format),
    .cmd            (cmd),
    .stat           (stat),
    .status         (status),
    .h_inc_word     (h_inc_word),
    .step_word      (step_word),
    .v_inc_word     (v_inc_word),
    .start_word     (start_word),
    .end_word       (end_word),
    .key_value      (key_value),
    .key_mask_word  (key_mask_word),
    .key_control    (key_control),
    .accum_init_p1  (accum_init_p1),
    .accum_init_p23 (accum_init_p23),
    .scale_control  (scale_control)
  );

endmodule

`default_nettype wire

[rtl/osc_checker.sv]
// Port-level checker for the overlay scaler setup calculator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module osc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [28:0] h_inc_word,
  input logic [29:0] v_inc_word,
  input logic [6:0]  key_control
);

  // An accepted item keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  // A result shows only while the block is idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // No result can follow an accepted item in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done)
    else $error("result strobe right after accept");

  // A rejected request carries no computed words.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != osc_pkg::ST_OK |->
      h_inc_word == '0 && v_inc_word == '0 && key_control == '0)
    else $error("rejected request with nonzero result words");

  // An accepted request carries one of the two key control values.
  a_key_control: assert property (@(posedge clk) disable iff (rst)
    done && status == osc_pkg::ST_OK |->
      key_control == osc_pkg::KEY_CTL_OFF || key_control == osc_pkg::KEY_CTL_ON)
    else $error("unexpected key control value");

endmodule

bind overlay_scaler_setup_calc osc_checker u_osc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .h_inc_word  (h_inc_word),
  .v_inc_word  (v_inc_word),
  .key_control (key_control)
);

`default_nettype wire
